/* rtl/iir_filter_direct_form_one_macros.svh */
// Assertion macros shared by the checkers of the direct form I IIR filter.
// Depends on nothing; files that assert take it in by include.
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define IIR_DF1_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define IIR_DF1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/iir_df1_pkg.sv */
// Types and constants of the direct form I IIR filter.
// Depends on nothing; used by the interfaces, the filter and its checker.
package iir_df1_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 24;
  localparam int ORDER_W     = 4;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT  = 18;
  localparam int RND_HALF    = 2 ** (FRAC_SHIFT - 1);
  localparam int SAMPLE_MAX  = 32767;
  localparam int SAMPLE_MIN  = -32768;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_LOAD_FB = 2'd1,
    KIND_LOAD_FF = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_ORDER = 2'd0,
    CFG_FF_ORDER = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ADD,
    S_RND,
    S_SAT
  } state_e;

endpackage

/* rtl/iir_df1_if.sv */
// Valid/ready channel interfaces of the direct form I IIR filter.
// Depends on iir_df1_pkg for the field widths.
interface iir_df1_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [iir_df1_pkg::KIND_W-1:0]      kind;
  logic        [iir_df1_pkg::ORDER_W-1:0]     coef_index;
  logic signed [iir_df1_pkg::COEF_W-1:0]      coef_value;
  logic signed [iir_df1_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, kind, coef_index, coef_value, sample, input ready);
  modport sink (input valid, kind, coef_index, coef_value, sample, output ready);
endinterface

interface iir_df1_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [iir_df1_pkg::SAMPLE_W-1:0]    filtered;
  logic                                       clipped;

  modport source (output valid, filtered, clipped, input ready);
  modport sink (input valid, filtered, clipped, output ready);
endinterface

interface iir_df1_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [iir_df1_pkg::CFG_IDX_W-1:0]          index;
  logic [iir_df1_pkg::ORDER_W-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/iir_filter_direct_form_one.sv */
// Direct form I IIR filter with one shared 16 x 24 bit multiplier.
// Items are taken only in idle. A load item or an unused kind leaves the sequencer idle. A sample
// item runs through the states MAC, ADD, RND and SAT; its result enters the output register as it
// retires from SAT, and only then is the next item taken: the multiplier serves one tap a cycle.
// Reset clears both orders, all coefficients and both delay lines to zero.
// Depends on iir_df1_pkg and the channel interfaces in iir_df1_if.sv.
module iir_filter_direct_form_one #(
  parameter int MAX_ORDER = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iir_df1_cfg_if.sink  cfg_i,
  iir_df1_in_if.sink   in_i,
  iir_df1_out_if.source out_o
);
  import iir_df1_pkg::*;

  // Width of a clamped order, of a table index and of the tap counter. The accumulator holds
  // the exact sum of up to 2 * MAX_ORDER + 1 full products.
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int TW    = $clog2(2 * MAX_ORDER + 1);
  localparam int ACC_W = PROD_W + $clog2(2 * MAX_ORDER + 2);
  localparam int RW    = ACC_W - FRAC_SHIFT;

  localparam logic signed [RW-1:0] SAT_HI = RW'(SAMPLE_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(SAMPLE_MIN);

  state_e state_q, state_d;

  logic [ORDER_W-1:0] fb_order_q, ff_order_q;

  // Coefficient tables. The feedforward tap on the current sample at the top position of the
  // table is kept apart, so that the array itself never exceeds MAX_ORDER entries.
  logic signed [COEF_W-1:0]   fb_coef_q [MAX_ORDER];
  logic signed [COEF_W-1:0]   ff_coef_q [MAX_ORDER];
  logic signed [COEF_W-1:0]   ff_top_q;

  // Delay lines: entry d holds the value delayed by d + 1 samples.
  logic signed [SAMPLE_W-1:0] xh_q [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] yh_q [MAX_ORDER];

  logic signed [SAMPLE_W-1:0] x_q;
  logic [OW-1:0]              na_q, nb_q;
  logic [OW-1:0]              na_clamp, nb_clamp;
  logic [TW-1:0]              term_q;
  logic [TW-1:0]              term_last;

  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [COEF_W-1:0]   op_b;
  logic                       op_sub;
  logic [TW-1:0]              hist_idx, coef_idx;

  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_vld_q, prod_sub_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [RW-1:0]       rnd_q;

  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       sat_clip;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                       clipped_q;
  logic                       out_vld_q;

  logic                       in_xfer, sample_xfer, issue, retire;
  logic [IW+ORDER_W-1:0]      load_idx;

  // ------------------------------------------------------------------------------------------
  // Handshakes. The input side is open only while the sequencer idles; the output register
  // parts the two sides, so a new sample may start while the last result still waits.
  // ------------------------------------------------------------------------------------------
  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = (state_q == S_IDLE);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign sample_xfer  = in_xfer && (in_i.kind == KIND_SAMPLE);
  assign out_o.valid  = out_vld_q;
  assign out_o.filtered = filtered_q;
  assign out_o.clipped  = clipped_q;

  // A result can be retired into the output register once that register is free or is being
  // emptied in the same cycle.
  assign retire = (state_q == S_SAT) && (!out_vld_q || out_o.ready);
  assign issue  = (state_q == S_MAC);

  // Orders above the table depth count as the full depth.
  assign na_clamp = (32'(fb_order_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(fb_order_q);
  assign nb_clamp = (32'(ff_order_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(ff_order_q);
  assign term_last = TW'(na_q) + TW'(nb_q);

  assign load_idx = (IW + ORDER_W)'(in_i.coef_index);

  // ------------------------------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_order_q <= '0;
      ff_order_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_FB_ORDER: fb_order_q <= cfg_i.data;
        CFG_FF_ORDER: ff_order_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------------------------
  // Coefficient loads. A position beyond the table is dropped without a result.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        fb_coef_q[i] <= '0;
        ff_coef_q[i] <= '0;
      end
      ff_top_q <= '0;
    end else if (in_xfer) begin
      unique case (kind_e'(in_i.kind))
        KIND_LOAD_FB: begin
          if (32'(in_i.coef_index) < MAX_ORDER) begin
            fb_coef_q[load_idx[IW-1:0]] <= in_i.coef_value;
          end
        end
        KIND_LOAD_FF: begin
          if (32'(in_i.coef_index) < MAX_ORDER) begin
            ff_coef_q[load_idx[IW-1:0]] <= in_i.coef_value;
          end else if (32'(in_i.coef_index) == MAX_ORDER) begin
            ff_top_q <= in_i.coef_value;
          end
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------------------------
  // Sequencer. Tap 0 is the current sample against the feedforward coefficient at position
  // nb. Taps 1 to na walk the feedback table from the oldest coefficient, paired with the
  // output delay line from its deepest used entry; the remaining nb taps do the same for the
  // feedforward table and the input delay line. Each multiply is registered and added in the
  // following cycle, so the ADD state drains the last product before rounding.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (sample_xfer) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (term_q == term_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: state_d = S_RND;
      S_RND: state_d = S_SAT;
      S_SAT: begin
        if (retire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Per-sample operands: the orders are frozen for the whole sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
      na_q   <= '0;
      nb_q   <= '0;
    end else if (sample_xfer) begin
      term_q <= '0;
      na_q   <= na_clamp;
      nb_q   <= nb_clamp;
    end else if (issue) begin
      term_q <= term_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_xfer) begin
      x_q <= in_i.sample;
    end
  end

  // Operand selection for the current tap.
  always_comb begin
    op_a     = x_q;
    op_b     = ff_top_q;
    op_sub   = 1'b0;
    hist_idx = '0;
    coef_idx = '0;
    if (term_q == '0) begin
      coef_idx = TW'(nb_q);
      if (nb_q == OW'(MAX_ORDER)) begin
        op_b = ff_top_q;
      end else begin
        op_b = ff_coef_q[coef_idx[IW-1:0]];
      end
    end else if (term_q <= TW'(na_q)) begin
      hist_idx = TW'(na_q) - term_q;
      coef_idx = term_q - TW'(1);
      op_a     = yh_q[hist_idx[IW-1:0]];
      op_b     = fb_coef_q[coef_idx[IW-1:0]];
      op_sub   = 1'b1;
    end else begin
      hist_idx = term_last - term_q;
      coef_idx = term_q - TW'(na_q) - TW'(1);
      op_a     = xh_q[hist_idx[IW-1:0]];
      op_b     = ff_coef_q[coef_idx[IW-1:0]];
    end
  end

  // The shared multiplier and its product register.
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= issue;
      prod_sub_q <= op_sub;
    end
  end

  // Exact accumulation of the products.
  always_ff @(posedge clk_i) begin
    if (sample_xfer) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      if (prod_sub_q) begin
        acc_q <= acc_q - ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Round half towards plus infinity, then drop the fraction below Q1.15.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RND) begin
      rnd_q <= RW'((acc_q + ACC_W'(RND_HALF)) >>> FRAC_SHIFT);
    end
  end

  // Saturation to the sample range.
  always_comb begin
    sat_val  = rnd_q[SAMPLE_W-1:0];
    sat_clip = 1'b0;
    if (rnd_q > SAT_HI) begin
      sat_val  = SAMPLE_W'(SAMPLE_MAX);
      sat_clip = 1'b1;
    end else if (rnd_q < SAT_LO) begin
      sat_val  = SAMPLE_W'(SAMPLE_MIN);
      sat_clip = 1'b1;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Retirement: the delay lines always shift their full depth, whatever the orders, so that
  // a raised order later sees the true older samples. The saturated output is what is kept.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (retire) begin
      for (int i = MAX_ORDER - 1; i > 0; i--) begin
        xh_q[i] <= xh_q[i-1];
        yh_q[i] <= yh_q[i-1];
      end
      xh_q[0] <= x_q;
      yh_q[0] <= sat_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      filtered_q <= sat_val;
      clipped_q  <= sat_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (retire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

endmodule

/* rtl/iir_df1_chk.sv */
// Port-level checker of the direct form I IIR filter, bound to its top level.
// Depends on iir_df1_pkg and iir_filter_direct_form_one_macros.svh.
`include "iir_filter_direct_form_one_macros.svh"

module iir_df1_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic [iir_df1_pkg::KIND_W-1:0]         in_kind_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [iir_df1_pkg::SAMPLE_W-1:0] out_filtered_i,
  input logic                                   out_clipped_i
);
  import iir_df1_pkg::*;

  // A waiting result stays offered until its transfer.
  `IIR_DF1_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i,
    "result withdrawn before transfer")

  // Its payload does not change while it waits.
  `IIR_DF1_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i,
    $stable(out_filtered_i) && $stable(out_clipped_i), "waiting result changed")

  // The input side closes only when a sample has been taken.
  `IIR_DF1_ASSERT(a_busy_after_sample, clk_i, rst_ni,
    $fell(in_ready_i) |-> $past(in_valid_i && in_kind_i == KIND_SAMPLE),
    "input closed without a sample transfer")

  // Loads and unused kinds finish in their own cycle.
  `IIR_DF1_ASSERT_NEXT(a_load_single_cycle, clk_i, rst_ni,
    in_valid_i && in_ready_i && in_kind_i != KIND_SAMPLE, in_ready_i,
    "non-sample item held the input closed")

endmodule

bind iir_filter_direct_form_one iir_df1_chk u_iir_df1_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_filtered_i (out_o.filtered),
  .out_clipped_i  (out_o.clipped)
);
